@@ sv/vdi_pkg.sv @@
// Shared types and constants for the vertex dedup indexer.
// No dependencies; imported by the channel interfaces and the top level.
package vdi_pkg;

   localparam int MAX_UNIQUE  = 4096;
   localparam int INDEX_WIDTH = 24;
   localparam int ADDR_WIDTH  = $clog2(MAX_UNIQUE);
   localparam int COUNT_WIDTH = $clog2(MAX_UNIQUE + 1);
   localparam int UIDX_WIDTH  = 12;
   localparam int TOTAL_WIDTH = 25;
   localparam int CSR_IDX_WIDTH = 1;

   typedef logic [INDEX_WIDTH-1:0] idx_type;
   typedef logic [ADDR_WIDTH-1:0]  addr_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [UIDX_WIDTH-1:0]  uidx_type;
   typedef logic [TOTAL_WIDTH-1:0] total_type;
   typedef logic [CSR_IDX_WIDTH-1:0] csr_idx_type;

   typedef struct packed {
      idx_type p;
      idx_type t;
      idx_type n;
   } triple_type;

   localparam csr_idx_type CSR_TEXCOORD_TOTAL = 1'b0;
   localparam csr_idx_type CSR_NORMAL_TOTAL   = 1'b1;

endpackage

@@ sv/vdi_req_if.sv @@
// Request channel: one mesh corner per word, valid/ready handshake.
// Depends on vdi_pkg.
interface vdi_req_if import vdi_pkg::*;;
   logic    valid;
   logic    ready;
   logic    first_of_mesh;
   idx_type position_index;
   idx_type texcoord_index;
   idx_type normal_index;

   modport source (output valid, first_of_mesh, position_index, texcoord_index,
                   normal_index, input ready);
   modport sink   (input valid, first_of_mesh, position_index, texcoord_index,
                   normal_index, output ready);
endinterface

@@ sv/vdi_rsp_if.sv @@
// Response channel: one dedup result per word, valid/ready handshake.
// Depends on vdi_pkg.
interface vdi_rsp_if import vdi_pkg::*;;
   logic     valid;
   logic     ready;
   uidx_type unique_index;
   logic     is_new;
   logic     set_full;
   logic     texcoords_used;
   logic     normals_used;

   modport source (output valid, unique_index, is_new, set_full, texcoords_used,
                   normals_used, input ready);
   modport sink   (input valid, unique_index, is_new, set_full, texcoords_used,
                   normals_used, output ready);
endinterface

@@ sv/vertex_dedup_indexer.sv @@
// Flow: an accepted corner is compared in ST_SCAN against the stored entries until
//   a match or the last entry (skipped for an empty set), then answered from ST_EMIT.
// One corner is handled at a time (ready only in ST_IDLE); the scan is bound by the
//   single read port of the triple memory, which is scanned one entry per cycle.
// Reset: clears state, entry count, sticky flags, totals and the response valid bit;
//   the triple memory is not cleared, entries at or above the count are never compared.
module vertex_dedup_indexer import vdi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   vdi_req_if.sink          req_chan,
   vdi_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  csr_idx_type      csr_index,
   input  total_type        csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   count_type  entry_count_ff, entry_count_in;
   logic       tex_seen_ff, tex_seen_in;
   logic       nrm_seen_ff, nrm_seen_in;
   total_type  tex_total_ff, nrm_total_ff;
   triple_type key_ff, key_in;
   addr_type   rd_idx_ff, rd_idx_in;
   addr_type   hit_idx_ff, hit_idx_in;
   logic       found_ff, found_in;

   logic       rsp_valid_ff, rsp_valid_in;
   uidx_type   rsp_index_ff, rsp_index_in;
   logic       rsp_new_ff, rsp_new_in;
   logic       rsp_full_ff, rsp_full_in;
   logic       rsp_tex_ff, rsp_tex_in;
   logic       rsp_nrm_ff, rsp_nrm_in;

   triple_type triple_mem [MAX_UNIQUE];
   triple_type mem_rd_ff;
   addr_type   rd_addr;
   logic       mem_we;

   logic       accept;
   logic       out_free;
   logic       emit_go;
   logic       set_full;
   logic       hit;
   logic       last_entry;
   count_type  base_count;
   logic       tex_valid, nrm_valid;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit_go  = (state_ff == ST_EMIT) && out_free;
   assign set_full = (entry_count_ff == count_type'(MAX_UNIQUE));
   assign hit      = (mem_rd_ff == key_ff);
   assign last_entry = (count_type'(rd_idx_ff) + count_type'(1)) == entry_count_ff;
   assign mem_we   = emit_go && !found_ff && !set_full;

   assign base_count = req_chan.first_of_mesh ? '0 : entry_count_ff;
   assign tex_valid  = (req_chan.texcoord_index != '0) &&
                       ({1'b0, req_chan.texcoord_index} < tex_total_ff);
   assign nrm_valid  = (req_chan.normal_index != '0) &&
                       ({1'b0, req_chan.normal_index} < nrm_total_ff);

   // Read address runs one ahead of the entry being compared.
   assign rd_addr = (state_ff == ST_IDLE) ? '0 : addr_type'(rd_idx_ff + addr_type'(1));

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      tex_seen_in    = tex_seen_ff;
      nrm_seen_in    = nrm_seen_ff;
      key_in         = key_ff;
      rd_idx_in      = rd_idx_ff;
      hit_idx_in     = hit_idx_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_index_in   = rsp_index_ff;
      rsp_new_in     = rsp_new_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_tex_in     = rsp_tex_ff;
      rsp_nrm_in     = rsp_nrm_ff;

      unique case (state_ff)
         ST_IDLE: begin
            rd_idx_in = rd_addr;
            if (accept) begin
               key_in         = '{p: req_chan.position_index,
                                  t: req_chan.texcoord_index,
                                  n: req_chan.normal_index};
               entry_count_in = base_count;
               tex_seen_in    = (tex_seen_ff && !req_chan.first_of_mesh) || tex_valid;
               nrm_seen_in    = (nrm_seen_ff && !req_chan.first_of_mesh) || nrm_valid;
               found_in       = 1'b0;
               state_in       = (base_count == '0) ? ST_EMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_idx_in = rd_addr;
            if (hit) begin
               found_in   = 1'b1;
               hit_idx_in = rd_idx_ff;
               state_in   = ST_EMIT;
            end else if (last_entry) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tex_in   = tex_seen_ff;
               rsp_nrm_in   = nrm_seen_ff;
               if (found_ff) begin
                  rsp_index_in = uidx_type'(hit_idx_ff);
                  rsp_new_in   = 1'b0;
                  rsp_full_in  = 1'b0;
               end else if (set_full) begin
                  rsp_index_in = '0;
                  rsp_new_in   = 1'b0;
                  rsp_full_in  = 1'b1;
               end else begin
                  rsp_index_in   = uidx_type'(entry_count_ff);
                  rsp_new_in     = 1'b1;
                  rsp_full_in    = 1'b0;
                  entry_count_in = entry_count_ff + count_type'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         tex_seen_ff    <= 1'b0;
         nrm_seen_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         tex_total_ff   <= '0;
         nrm_total_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         tex_seen_ff    <= tex_seen_in;
         nrm_seen_ff    <= nrm_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TEXCOORD_TOTAL: tex_total_ff <= csr_wdata;
               CSR_NORMAL_TOTAL:   nrm_total_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      found_ff     <= found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_tex_ff   <= rsp_tex_in;
      rsp_nrm_ff   <= rsp_nrm_in;
   end

   // Triple store: one write port for appends, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         triple_mem[addr_type'(entry_count_ff)] <= key_ff;
      end
      mem_rd_ff <= triple_mem[rd_addr];
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.unique_index   = rsp_index_ff;
   assign rsp_chan.is_new         = rsp_new_ff;
   assign rsp_chan.set_full       = rsp_full_ff;
   assign rsp_chan.texcoords_used = rsp_tex_ff;
   assign rsp_chan.normals_used   = rsp_nrm_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= count_type'(MAX_UNIQUE))
      else $error("entry count above capacity");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_type'(rd_idx_ff) < entry_count_ff))
      else $error("scan past last stored entry");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> (entry_count_ff == $past(entry_count_ff) + count_type'(1)))
      else $error("append did not advance entry count");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> (rsp_index_ff == '0 && !rsp_new_ff))
      else $error("full result carries index or new flag");

   a_no_write_when_found: assert property (@(posedge clock) disable iff (reset)
      (emit_go && found_ff) |-> !mem_we)
      else $error("append on a matched triple");

endmodule
